// ===== sv/assert_macros.svh =====
// assertion helpers used by msfsp_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle
`define MSFSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// condition in the next cycle
`define MSFSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/msfsp_pkg.sv =====
package msfsp_pkg;

    // result kinds
    localparam logic [1:0] KIND_UNIT    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // section layouts
    localparam logic SECTION_AUDIO = 1'b0;

    // record sizes before the completing byte, crc skip
    localparam logic [2:0] AUDIO_RECORD_LEN = 3'd4;
    localparam logic [2:0] DATA_RECORD_LEN  = 3'd2;
    localparam logic [2:0] CRC_LAST         = 3'd3;

    // one accepted input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       section_start;
    } item_t;

    // one result item
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  unit_index;
        logic [15:0] unit_length;
        logic [2:0]  strm_id;
        logic [15:0] rel_play;
        logic [7:0]  data_type;
        logic [7:0]  payload_byte;
        logic        unit_end;
        logic        section_end;
    } res_t;

    // link to the next unit of nonzero length
    typedef struct packed {
        logic [7:0]  idx;
        logic [15:0] len;
    } link_t;

    // link table write
    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        link_t       data;
    } link_wr_t;

endpackage

// ===== sv/mux_sub_frame_section_parser.sv =====
// channel   ports                                   direction
// input     s_valid s_ready s_in_byte                in
//           s_section_start
// result    m_valid m_ready m_result_kind ...        out
//           m_section_end
// config    cfg_wr_en cfg_wr_data (section kind)     in
//
// one item per cycle unless m_ready stalls; input register, then result register
// empty units are skipped in payload: the link table chains the units of nonzero length
// aresetn is synchronous, active low; no table clearing pass, entries are written before use
// m_ready low holds the result register; the input register then holds one item
module mux_sub_frame_section_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_section_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_unit_index,
    output logic [15:0] m_unit_length,
    output logic [2:0]  m_strm_id,
    output logic [15:0] m_rel_play,
    output logic [7:0]  m_data_type,
    output logic [7:0]  m_payload_byte,
    output logic        m_unit_end,
    output logic        m_section_end
);

    logic                section_kind_reg;
    logic                item_vld;
    msfsp_pkg::item_t    item;
    logic                take;
    msfsp_pkg::res_t     res;
    msfsp_pkg::link_wr_t wr;
    logic [7:0]          rd_addr;
    msfsp_pkg::link_t    rd_data;

    // section kind register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_kind_reg <= msfsp_pkg::SECTION_AUDIO;
        end else if (cfg_wr_en) begin
            section_kind_reg <= cfg_wr_data;
        end
    end

    // input register
    msfsp_in_reg u_in_reg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_section_start (s_section_start),
        .take            (take),
        .item_vld        (item_vld),
        .item            (item)
    );

    // parser and result register
    msfsp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .section_kind (section_kind_reg),
        .item_vld     (item_vld),
        .item         (item),
        .take         (take),
        .m_vld        (m_valid),
        .m_ready      (m_ready),
        .res          (res),
        .wr           (wr),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    // next-unit link table
    msfsp_link_ram u_link_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result fields
    assign m_result_kind  = res.result_kind;
    assign m_unit_index   = res.unit_index;
    assign m_unit_length  = res.unit_length;
    assign m_strm_id      = res.strm_id;
    assign m_rel_play     = res.rel_play;
    assign m_data_type    = res.data_type;
    assign m_payload_byte = res.payload_byte;
    assign m_unit_end     = res.unit_end;
    assign m_section_end  = res.section_end;

endmodule

// ===== sv/msfsp_in_reg.sv =====
module msfsp_in_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             s_section_start,
    input  logic             take,
    output logic             item_vld,
    output msfsp_pkg::item_t item
);

    logic             vld_reg;
    logic             vld_next;
    msfsp_pkg::item_t item_reg;
    logic             load;

    // accept when empty or when the held item leaves in this cycle
    assign s_ready  = !vld_reg || take;
    assign load     = s_valid && s_ready;
    assign vld_next = load ? 1'b1 : (take ? 1'b0 : vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // held item
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.in_byte       <= s_in_byte;
            item_reg.section_start <= s_section_start;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

// ===== sv/msfsp_link_ram.sv =====
module msfsp_link_ram (
    input  logic                aclk,
    input  msfsp_pkg::link_wr_t wr,
    input  logic [7:0]          rd_addr,
    output msfsp_pkg::link_t    rd_data
);

    msfsp_pkg::link_t mem [256];
    msfsp_pkg::link_t rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/msfsp_core.sv =====
`include "assert_macros.svh"

module msfsp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                section_kind,
    input  logic                item_vld,
    input  msfsp_pkg::item_t    item,
    output logic                take,
    output logic                m_vld,
    input  logic                m_ready,
    output msfsp_pkg::res_t     res,
    output msfsp_pkg::link_wr_t wr,
    output logic [7:0]          rd_addr,
    input  msfsp_pkg::link_t    rd_data
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_RECORD  = 2'd1;
    localparam logic [1:0] PH_CRC     = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       cur_reg, cur_next;
    logic [15:0]      cur_len_reg, cur_len_next;
    logic [15:0]      rem_reg, rem_next;
    logic [2:0]       pos_reg, pos_next;
    logic [31:0]      partial_reg, partial_next;
    logic [2:0]       crc_reg, crc_next;
    logic             have_nz_reg, have_nz_next;
    logic [7:0]       first_nz_reg, first_nz_next;
    logic [15:0]      first_len_reg, first_len_next;
    logic [7:0]       last_nz_reg, last_nz_next;
    logic             out_vld_reg, out_vld_next;
    msfsp_pkg::res_t  res_reg, res_next;
    logic             emit;
    logic             proc;
    logic [2:0]       rec_last;
    logic [15:0]      rec_len;
    logic [8:0]       cur_inc;
    logic [15:0]      rem_dec;

    // an item is processed when the result register can take its result
    assign proc     = item_vld && (!out_vld_reg || m_ready);
    assign take     = proc;
    assign rec_last = (section_kind == msfsp_pkg::SECTION_AUDIO) ?
                      msfsp_pkg::AUDIO_RECORD_LEN : msfsp_pkg::DATA_RECORD_LEN;
    assign rec_len  = (section_kind == msfsp_pkg::SECTION_AUDIO) ?
                      partial_reg[31:16] : {partial_reg[7:0], item.in_byte};
    assign cur_inc  = {1'b0, cur_reg} + 9'd1;
    assign rem_dec  = rem_reg - 16'd1;

    // parser next state and result
    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        cur_len_next   = cur_len_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        partial_next   = partial_reg;
        crc_next       = crc_reg;
        have_nz_next   = have_nz_reg;
        first_nz_next  = first_nz_reg;
        first_len_next = first_len_reg;
        last_nz_next   = last_nz_reg;
        res_next       = '0;
        emit           = 1'b0;
        wr             = '0;

        if (proc) begin
            if (item.section_start) begin
                // unit count opens a section
                count_next   = item.in_byte;
                cur_next     = 8'd0;
                pos_next     = 3'd0;
                partial_next = 32'd0;
                rem_next     = 16'd0;
                crc_next     = 3'd0;
                have_nz_next = 1'b0;
                phase_next   = (item.in_byte == 8'd0) ? PH_CRC : PH_RECORD;
            end else begin
                case (phase_reg)
                    PH_RECORD: begin
                        if (pos_reg < rec_last) begin
                            partial_next = {partial_reg[23:0], item.in_byte};
                            pos_next     = pos_reg + 3'd1;
                        end else begin
                            // record complete: descriptor out
                            emit                 = 1'b1;
                            res_next.result_kind = msfsp_pkg::KIND_UNIT;
                            res_next.unit_index  = cur_reg;
                            res_next.unit_length = rec_len;
                            if (section_kind == msfsp_pkg::SECTION_AUDIO) begin
                                res_next.strm_id  = partial_reg[10:8];
                                res_next.rel_play = {partial_reg[7:0], item.in_byte};
                            end else begin
                                res_next.data_type = partial_reg[15:8];
                            end
                            // chain units of nonzero length
                            if (rec_len != 16'd0) begin
                                if (have_nz_reg) begin
                                    wr.en       = 1'b1;
                                    wr.addr     = last_nz_reg;
                                    wr.data.idx = cur_reg;
                                    wr.data.len = rec_len;
                                end else begin
                                    first_nz_next  = cur_reg;
                                    first_len_next = rec_len;
                                end
                                have_nz_next = 1'b1;
                                last_nz_next = cur_reg;
                            end
                            cur_next     = cur_inc[7:0];
                            pos_next     = 3'd0;
                            partial_next = 32'd0;
                            if (cur_inc >= {1'b0, count_reg}) begin
                                phase_next = PH_CRC;
                                crc_next   = 3'd0;
                            end
                        end
                    end
                    PH_CRC: begin
                        if (crc_reg < msfsp_pkg::CRC_LAST) begin
                            crc_next = crc_reg + 3'd1;
                        end else begin
                            crc_next = 3'd0;
                            if (!have_nz_reg) begin
                                // nothing to deliver: bare end marker
                                cur_next             = 8'd0;
                                phase_next           = PH_IDLE;
                                emit                 = 1'b1;
                                res_next.result_kind = msfsp_pkg::KIND_END;
                                res_next.section_end = 1'b1;
                            end else begin
                                cur_next     = first_nz_reg;
                                cur_len_next = first_len_reg;
                                rem_next     = first_len_reg;
                                phase_next   = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        emit                  = 1'b1;
                        res_next.result_kind  = msfsp_pkg::KIND_PAYLOAD;
                        res_next.unit_index   = cur_reg;
                        res_next.unit_length  = cur_len_reg;
                        res_next.payload_byte = item.in_byte;
                        rem_next              = rem_dec;
                        if (rem_dec == 16'd0) begin
                            res_next.unit_end = 1'b1;
                            if (cur_reg == last_nz_reg) begin
                                cur_next             = 8'd0;
                                phase_next           = PH_IDLE;
                                res_next.section_end = 1'b1;
                            end else begin
                                // rd_data holds the link of the current unit
                                cur_next     = rd_data.idx;
                                cur_len_next = rd_data.len;
                                rem_next     = rd_data.len;
                            end
                        end
                    end
                    default: begin
                        // outside a section: byte dropped
                    end
                endcase
            end
        end
    end

    // link read follows the unit that becomes current
    assign rd_addr = cur_next;

    // result register handshake
    assign out_vld_next = proc ? emit : (out_vld_reg && !m_ready);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            have_nz_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            crc_reg     <= 3'd0;
            pos_reg     <= 3'd0;
            cur_reg     <= 8'd0;
            rem_reg     <= 16'd0;
        end else begin
            phase_reg   <= phase_next;
            have_nz_reg <= have_nz_next;
            out_vld_reg <= out_vld_next;
            crc_reg     <= crc_next;
            pos_reg     <= pos_next;
            cur_reg     <= cur_next;
            rem_reg     <= rem_next;
        end
    end

    // section fields and result payload
    always_ff @(posedge aclk) begin
        count_reg     <= count_next;
        cur_len_reg   <= cur_len_next;
        partial_reg   <= partial_next;
        first_nz_reg  <= first_nz_next;
        first_len_reg <= first_len_next;
        last_nz_reg   <= last_nz_next;
        if (proc) begin
            res_reg <= res_next;
        end
    end

    assign m_vld = out_vld_reg;
    assign res   = res_reg;

    // checks
    `MSFSP_ASSERT_NOW(a_payload_rem_nonzero, phase_reg == PH_PAYLOAD, rem_reg != 16'd0,
        "payload phase with no bytes remaining")
    `MSFSP_ASSERT_NOW(a_crc_range, 1'b1, crc_reg <= msfsp_pkg::CRC_LAST,
        "crc skip count out of range")
    `MSFSP_ASSERT_NEXT(a_start_phase, proc && item.section_start,
        phase_reg == PH_RECORD || phase_reg == PH_CRC,
        "section start did not open a section")
    `MSFSP_ASSERT_NOW(a_end_marks, out_vld_reg && res_reg.section_end &&
        res_reg.result_kind == msfsp_pkg::KIND_PAYLOAD, res_reg.unit_end,
        "section end on payload without unit end")

endmodule
